// ----- hw/rtl/wrvd_pkg.sv -----
package wrvd_pkg;

	// value width fixed by the item fields
	localparam int VW = 32;

	typedef logic signed [VW-1:0] value_t;

	localparam value_t VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam value_t VMIN = {1'b1, {(VW-1){1'b0}}};

	// opcodes on the input item
	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// command kinds after classification
	localparam logic [1:0] KIND_NOP   = 2'd0;
	localparam logic [1:0] KIND_SET   = 2'd1;
	localparam logic [1:0] KIND_ADD   = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 1'b1;

	// bound reset values, -180.0 and 180.0 in Q16.16
	localparam value_t LOWER_BOUND_RESET = 32'shFF4C0000;
	localparam value_t UPPER_BOUND_RESET = 32'sh00B40000;

	typedef struct packed {
		logic [1:0] opcode;
		value_t     operand;
	} item_t;

	typedef struct packed {
		value_t current_value;
		value_t shortest_difference;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		value_t     operand;
	} cmd_t;

	// handshake between command queue and sequencer
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_src_t;

endpackage

// ----- hw/rtl/wrapped_range_value_difference.sv -----
// channel  | direction | handshake            | payload
// item     | in        | push / full          | opcode, operand
// result   | out       | empty / pop          | current_value, shortest_difference
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item passes through the input stage register and the command queue, then
// the sequencer: an unused opcode goes straight to S_DONE, an in-range value
// skips the fold, and an out-of-range value is folded by the 32-step restoring
// remainder unit; a query also runs S_CAND, S_MAG and S_PICK.
// Reset (arst_n low) empties all stages, clears the stored value and loads
// the bounds with -180.0 and 180.0. Items keep entering the queue while the
// sequencer waits on a full result register; cfg_ready is always high.
module wrapped_range_value_difference #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  wrvd_pkg::item_t                    item,
	output logic                               empty,
	input  logic                               pop,
	output wrvd_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wrvd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wrvd_pkg::value_t                   cfg_data
);

	wrvd_pkg::value_t   lower_bound_q;
	wrvd_pkg::value_t   upper_bound_q;
	logic               q_full;
	logic               q_wr;
	wrvd_pkg::cmd_t     q_data;
	wrvd_pkg::cmd_src_t src;
	logic               take;

	assign cfg_ready = 1'b1;

	// bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_bound_q <= wrvd_pkg::LOWER_BOUND_RESET;
			upper_bound_q <= wrvd_pkg::UPPER_BOUND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wrvd_pkg::REG_LOWER_BOUND: lower_bound_q <= cfg_data;
				wrvd_pkg::REG_UPPER_BOUND: upper_bound_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wrvd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (q_data)
	);

	wrvd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_data),
		.q_full  (q_full),
		.rd      (take),
		.src     (src)
	);

	wrvd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.src         (src),
		.take        (take),
		.lower_bound (lower_bound_q),
		.upper_bound (upper_bound_q),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

// ----- hw/rtl/wrvd_front.sv -----
module wrvd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  wrvd_pkg::item_t   item,
	input  logic              q_full,
	output logic              q_wr,
	output wrvd_pkg::cmd_t    q_data
);

	logic           vld_s1;
	wrvd_pkg::cmd_t cmd_s1;
	logic           accept;
	logic [1:0]     kind;

	// classify the opcode into a command kind
	always_comb begin
		case (item.opcode)
			wrvd_pkg::OP_SET:   kind = wrvd_pkg::KIND_SET;
			wrvd_pkg::OP_ADD:   kind = wrvd_pkg::KIND_ADD;
			wrvd_pkg::OP_QUERY: kind = wrvd_pkg::KIND_QUERY;
			default:            kind = wrvd_pkg::KIND_NOP;
		endcase
	end

	// stage register drains into the queue whenever it has room
	assign q_wr   = vld_s1 && !q_full;
	assign q_data = cmd_s1;
	assign full   = vld_s1 && q_full;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind    <= kind;
			cmd_s1.operand <= item.operand;
		end
	end

endmodule

// ----- hw/rtl/wrvd_queue.sv -----
module wrvd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  wrvd_pkg::cmd_t      wr_data,
	output logic                q_full,
	input  logic                rd,
	output wrvd_pkg::cmd_src_t  src
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wrvd_pkg::cmd_t slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign q_full    = (count_q == CW'(DEPTH));
	assign src.valid = (count_q != '0);
	assign src.cmd   = slots_q[rd_ptr_q];
	assign do_wr     = wr && !q_full;
	assign do_rd     = rd && src.valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/wrvd_back.sv -----
module wrvd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wrvd_pkg::cmd_src_t  src,
	output logic                take,
	input  wrvd_pkg::value_t    lower_bound,
	input  wrvd_pkg::value_t    upper_bound,
	output logic                empty,
	input  logic                pop,
	output wrvd_pkg::result_t   result
);

	localparam int VW = wrvd_pkg::VW;
	localparam int CW = $clog2(VW);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RANGE = 4'd1;
	localparam logic [3:0] S_CLASS = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_FIX   = 4'd4;
	localparam logic [3:0] S_APPLY = 4'd5;
	localparam logic [3:0] S_CAND  = 4'd6;
	localparam logic [3:0] S_MAG   = 4'd7;
	localparam logic [3:0] S_PICK  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]              state_q;
	logic [1:0]              kind_q;
	wrvd_pkg::value_t        val_q;
	wrvd_pkg::value_t        x_q;
	wrvd_pkg::value_t        lo_q;
	wrvd_pkg::value_t        hi_q;
	wrvd_pkg::value_t        fold_q;
	wrvd_pkg::value_t        diff_q;
	logic [VW-1:0]           w_q;
	logic [VW-1:0]           num_q;
	logic [VW:0]             rem_q;
	logic [CW-1:0]           cnt_q;
	logic                    neg_q;
	logic signed [VW+2:0]    plain_q;
	logic signed [VW+2:0]    above_q;
	logic signed [VW+2:0]    below_q;
	logic [VW+1:0]           mplain_q;
	logic [VW+1:0]           mabove_q;
	logic [VW+1:0]           mbelow_q;
	logic                    out_vld_q;
	wrvd_pkg::result_t       out_q;

	logic signed [VW:0]      sum;
	wrvd_pkg::value_t        sum_sat;
	logic signed [VW:0]      width_ext;
	logic signed [VW:0]      d_lo;
	logic signed [VW:0]      d_hi;
	logic                    x_neg;
	logic                    x_pos;
	logic [VW:0]             shifted;
	logic [VW+1:0]           trial;
	logic signed [VW:0]      fixed;
	logic signed [VW+2:0]    best;
	logic                    out_free;
	logic                    load_out;

	function automatic logic [VW+1:0] mag35(input logic signed [VW+2:0] v);
		logic signed [VW+2:0] n;
		n = -v;
		return v[VW+2] ? n[VW+1:0] : v[VW+1:0];
	endfunction

	// saturating add for the offset command
	assign sum = {val_q[VW-1], val_q} + {src.cmd.operand[VW-1], src.cmd.operand};
	always_comb begin
		if (sum[VW] != sum[VW-1]) begin
			sum_sat = sum[VW] ? wrvd_pkg::VMIN : wrvd_pkg::VMAX;
		end else begin
			sum_sat = sum[VW-1:0];
		end
	end

	// range classification of the value to fold
	assign width_ext = {hi_q[VW-1], hi_q} - {lo_q[VW-1], lo_q};
	assign x_neg     = (x_q < lo_q);
	assign x_pos     = (x_q > hi_q);
	assign d_lo      = {lo_q[VW-1], lo_q} - {x_q[VW-1], x_q};
	assign d_hi      = {x_q[VW-1], x_q} - {hi_q[VW-1], hi_q};

	// one restoring remainder step
	assign shifted = {rem_q[VW-1:0], num_q[VW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, w_q};

	// fold result from the remainder
	always_comb begin
		if (neg_q) begin
			fixed = {hi_q[VW-1], hi_q} - {1'b0, rem_q[VW-1:0]};
		end else begin
			fixed = {lo_q[VW-1], lo_q} + {1'b0, rem_q[VW-1:0]};
		end
	end

	// pick the smallest candidate, plain one wins ties
	always_comb begin
		if (mabove_q < mbelow_q && mabove_q < mplain_q) begin
			best = above_q;
		end else if (mbelow_q < mabove_q && mbelow_q < mplain_q) begin
			best = below_q;
		end else begin
			best = plain_q;
		end
	end

	assign out_free = !out_vld_q || pop;
	assign load_out = (state_q == S_DONE) && out_free;
	assign take     = (state_q == S_IDLE) && src.valid;
	assign empty    = !out_vld_q;
	assign result   = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			val_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (src.valid) begin
						if (src.cmd.kind == wrvd_pkg::KIND_NOP) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RANGE;
						end
					end
				end
				S_RANGE: begin
					state_q <= S_CLASS;
				end
				S_CLASS: begin
					cnt_q <= '0;
					if (x_neg || x_pos) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(VW - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (kind_q == wrvd_pkg::KIND_QUERY) begin
						state_q <= S_CAND;
					end else begin
						val_q   <= fold_q;
						state_q <= S_DONE;
					end
				end
				S_CAND: begin
					state_q <= S_MAG;
				end
				S_MAG: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= src.cmd.kind;
				diff_q <= '0;
				if (src.cmd.kind == wrvd_pkg::KIND_ADD) begin
					x_q <= sum_sat;
				end else begin
					x_q <= src.cmd.operand;
				end
			end
			S_RANGE: begin
				if (lower_bound > upper_bound) begin
					lo_q <= upper_bound;
					hi_q <= lower_bound;
				end else begin
					lo_q <= lower_bound;
					hi_q <= upper_bound;
				end
			end
			S_CLASS: begin
				w_q    <= width_ext[VW-1:0];
				neg_q  <= x_neg;
				num_q  <= x_neg ? d_lo[VW-1:0] : d_hi[VW-1:0];
				rem_q  <= '0;
				fold_q <= x_q;
			end
			S_DIV: begin
				num_q <= {num_q[VW-2:0], 1'b0};
				rem_q <= trial[VW+1] ? shifted : trial[VW:0];
			end
			S_FIX: begin
				fold_q <= (w_q == '0) ? lo_q : fixed[VW-1:0];
			end
			S_APPLY: begin
				plain_q <= {{3{fold_q[VW-1]}}, fold_q} - {{3{val_q[VW-1]}}, val_q};
			end
			S_CAND: begin
				above_q <= plain_q - {3'b000, w_q};
				below_q <= plain_q + {3'b000, w_q};
			end
			S_MAG: begin
				mplain_q <= mag35(plain_q);
				mabove_q <= mag35(above_q);
				mbelow_q <= mag35(below_q);
			end
			S_PICK: begin
				if (best[VW+2:VW-1] == {4{best[VW-1]}}) begin
					diff_q <= best[VW-1:0];
				end else begin
					diff_q <= best[VW+2] ? wrvd_pkg::VMIN : wrvd_pkg::VMAX;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.current_value       <= val_q;
			out_q.shortest_difference <= diff_q;
		end
	end

endmodule

// ----- hw/rtl/wrvd_checker.sv -----
module wrvd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input wrvd_pkg::result_t result,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	logic [7:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// a waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// no result without an outstanding item
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != 8'd0)
		else $error("result shown with no item outstanding");

	// an idle block takes items
	a_idle_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 8'd0 |-> !full)
		else $error("full while nothing outstanding");

	// configuration is never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind wrapped_range_value_difference wrvd_checker u_chk (.*);
